[hw/rtl/dtc_pkg.sv]
`timescale 1ns / 1ps

package dtc_pkg;

    localparam int COUNT_WIDTH_DEF = 64;
    localparam int HZ_W            = 30;
    localparam int DIV_W           = 64;
    localparam int DIV_CNT_W       = $clog2(DIV_W);
    localparam logic [HZ_W-1:0] NS_PER_SEC = 30'd1000000000;

    // 10^9 = 2^9 * 5^9; reciprocal of the odd factor scaled by 2^56
    localparam logic [63:0] NS_ODD   = 64'd1953125;
    localparam logic [63:0] NS_RECIP = (64'd1 << 56) / NS_ODD;

    // Command codes on the func field
    localparam logic [2:0] FN_TICK     = 3'd0;
    localparam logic [2:0] FN_READ_NOW = 3'd1;
    localparam logic [2:0] FN_SET      = 3'd2;
    localparam logic [2:0] FN_CANCEL   = 3'd3;
    localparam logic [2:0] FN_RD_FIRED = 3'd4;

    // Register index of the tick rate
    localparam logic REG_TIMEBASE = 1'b0;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] target_ns;
    } cmd_t;

    typedef struct packed {
        logic [63:0] now_ns;
        logic        fired;
        logic        trap;
    } rsp_t;

    typedef enum logic [2:0] {
        K_TICK,
        K_NOW,
        K_SET,
        K_CANCEL,
        K_RD_FIRED,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] target_ns;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_out_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [HZ_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
    } cdiv_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [HZ_W-1:0]  rem;
    } div_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV1,
        S_MLO,
        S_MHI,
        S_MR,
        S_DIV2
    } state_t;

    // Steps of the divide by 10^9
    typedef enum logic [2:0] {
        C_LO_LO,
        C_LO_HI,
        C_HI_LO,
        C_HI_HI,
        C_Q_LO,
        C_Q_HI,
        C_FIX
    } cstep_t;

endpackage

[hw/rtl/dtc_front.sv]
`timescale 1ns / 1ps

module dtc_front
    import dtc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  cmd_t   cmd,
    output logic   busy,
    input  logic   pop,
    output q_out_t head
);

    entry_t     q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    kind_t      kind;

    // Classify the incoming beat
    always_comb
    begin
        case (cmd.func)
            FN_TICK:     kind = K_TICK;
            FN_READ_NOW: kind = K_NOW;
            FN_SET:      kind = K_SET;
            FN_CANCEL:   kind = K_CANCEL;
            FN_RD_FIRED: kind = K_RD_FIRED;
            default:     kind = K_NOP;
        endcase
    end

    assign busy = (cnt_reg == 2'd2);
    assign push = start && !busy;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the classified beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].kind      <= kind;
            q_reg[wr_ptr_reg].target_ns <= cmd.target_ns;
        end
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.entry = q_reg[rd_ptr_reg];

endmodule

[hw/rtl/dtc_div.sv]
`timescale 1ns / 1ps

module dtc_div
    import dtc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [HZ_W-1:0]      rem_reg, rem_next;
    logic [HZ_W-1:0]      dvs_reg, dvs_next;
    logic [HZ_W:0]        trial;
    logic [HZ_W:0]        diff;
    logic                 take;

    // One quotient bit per cycle, restoring
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        take  = (trial >= {1'b0, dvs_reg});

        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], take};
            rem_next = take ? diff[HZ_W-1:0] : trial[HZ_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// Divide by 10^9 through the scaled reciprocal of 5^9
module dtc_cdiv
    import dtc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cdiv_req_t req,
    output div_rsp_t  rsp
);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    cstep_t           step_reg, step_next;
    logic [63:0]      x_reg, x_next;
    logic [119:0]     acc_reg, acc_next;
    logic [63:0]      pr_reg, pr_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [HZ_W-1:0]  rem_reg, rem_next;
    logic [54:0]      xs;
    logic [63:0]      q_est;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      mul_p;
    logic [63:0]      r_est;
    logic [63:0]      r_fix;
    logic             over;

    // Drop the 2^9 factor; the estimate is low by at most one
    assign xs    = x_reg[63:9];
    assign q_est = acc_reg[119:56];
    assign r_est = x_reg - pr_reg;
    assign r_fix = r_est - {34'd0, NS_PER_SEC};
    assign over  = (r_est >= {34'd0, NS_PER_SEC});

    // Shared 32x32 multiplier
    always_comb
    begin
        case (step_reg)
            C_LO_LO:
            begin
                mul_a = xs[31:0];
                mul_b = NS_RECIP[31:0];
            end
            C_LO_HI:
            begin
                mul_a = xs[31:0];
                mul_b = NS_RECIP[63:32];
            end
            C_HI_LO:
            begin
                mul_a = {9'd0, xs[54:32]};
                mul_b = NS_RECIP[31:0];
            end
            C_HI_HI:
            begin
                mul_a = {9'd0, xs[54:32]};
                mul_b = NS_RECIP[63:32];
            end
            C_Q_LO:
            begin
                mul_a = q_est[31:0];
                mul_b = {2'b00, NS_PER_SEC};
            end
            C_Q_HI:
            begin
                mul_a = q_est[63:32];
                mul_b = {2'b00, NS_PER_SEC};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Accumulate partial products, form the remainder, correct by one
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        x_next    = x_reg;
        acc_next  = acc_reg;
        pr_next   = pr_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;

        if (req.start)
        begin
            run_next  = 1'b1;
            step_next = C_LO_LO;
            x_next    = req.dividend;
        end
        else if (run_reg)
        begin
            case (step_reg)
                C_LO_LO:
                begin
                    acc_next  = {56'd0, mul_p};
                    step_next = C_LO_HI;
                end
                C_LO_HI:
                begin
                    acc_next  = acc_reg + {24'd0, mul_p, 32'd0};
                    step_next = C_HI_LO;
                end
                C_HI_LO:
                begin
                    acc_next  = acc_reg + {24'd0, mul_p, 32'd0};
                    step_next = C_HI_HI;
                end
                C_HI_HI:
                begin
                    acc_next  = acc_reg + {mul_p[55:0], 64'd0};
                    step_next = C_Q_LO;
                end
                C_Q_LO:
                begin
                    pr_next   = mul_p;
                    step_next = C_Q_HI;
                end
                C_Q_HI:
                begin
                    pr_next   = pr_reg + {mul_p[31:0], 32'd0};
                    step_next = C_FIX;
                end
                C_FIX:
                begin
                    quo_next  = over ? (q_est + 64'd1) : q_est;
                    rem_next  = over ? r_fix[HZ_W-1:0] : r_est[HZ_W-1:0];
                    run_next  = 1'b0;
                    done_next = 1'b1;
                    step_next = C_LO_LO;
                end
                default:
                begin
                    run_next  = 1'b0;
                    step_next = C_LO_LO;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= C_LO_LO;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        acc_reg <= acc_next;
        pr_reg  <= pr_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

[hw/rtl/dtc_back.sv]
`timescale 1ns / 1ps

module dtc_back
    import dtc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [HZ_W-1:0] hz,
    input  q_out_t          head,
    output logic            pop,
    output div_req_t        dreq,
    input  div_rsp_t        drsp,
    output cdiv_req_t       creq,
    input  div_rsp_t        crsp,
    output logic            done,
    output rsp_t            rsp
);

    state_t                 state_reg, state_next;
    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic [COUNT_WIDTH-1:0] cmp_reg, cmp_next;
    logic                   armed_reg, armed_next;
    logic                   fired_reg, fired_next;
    logic                   is_set_reg, is_set_next;
    logic [63:0]            s_reg, s_next;
    logic [HZ_W-1:0]        r_reg, r_next;
    logic [63:0]            acc_reg, acc_next;
    logic                   done_reg, done_next;
    rsp_t                   rsp_reg, rsp_next;
    logic [HZ_W-1:0]        mul_k;
    logic [31:0]            mul_a;
    logic [61:0]            mul_p;
    logic [63:0]            sum;
    logic [COUNT_WIDTH-1:0] tick_inc;
    logic                   cv_done;
    logic [63:0]            cv_quot;
    logic [HZ_W-1:0]        cv_rem;

    // Constant factor and divider depend on conversion direction
    assign mul_k   = is_set_reg ? hz : NS_PER_SEC;
    assign cv_done = is_set_reg ? crsp.done : drsp.done;
    assign cv_quot = is_set_reg ? crsp.quot : drsp.quot;
    assign cv_rem  = is_set_reg ? crsp.rem : drsp.rem;

    // Shared 32x30 multiplier
    always_comb
    begin
        case (state_reg)
            S_MLO:   mul_a = s_reg[31:0];
            S_MHI:   mul_a = s_reg[63:32];
            default: mul_a = {2'b00, r_reg};
        endcase
        mul_p = mul_a * mul_k;
    end

    assign sum      = acc_reg + cv_quot;
    assign tick_inc = tick_reg + 1'b1;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        tick_next   = tick_reg;
        cmp_next    = cmp_reg;
        armed_next  = armed_reg;
        fired_next  = fired_reg;
        is_set_next = is_set_reg;
        s_next      = s_reg;
        r_next      = r_reg;
        acc_next    = acc_reg;
        done_next   = 1'b0;
        rsp_next    = '0;
        pop         = 1'b0;
        dreq.start    = 1'b0;
        dreq.dividend = '0;
        dreq.divisor  = hz;
        creq.start    = 1'b0;
        creq.dividend = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    done_next = 1'b1;
                    case (head.entry.kind)
                        K_TICK:
                        begin
                            tick_next = tick_inc;
                            if (armed_reg && (tick_inc >= cmp_reg))
                            begin
                                armed_next    = 1'b0;
                                fired_next    = 1'b1;
                                rsp_next.trap = 1'b1;
                            end
                        end
                        K_NOW:
                        begin
                            if (hz != '0)
                            begin
                                done_next     = 1'b0;
                                is_set_next   = 1'b0;
                                dreq.start    = 1'b1;
                                dreq.dividend = 64'(tick_reg);
                                dreq.divisor  = hz;
                                state_next    = S_DIV1;
                            end
                        end
                        K_SET:
                        begin
                            fired_next = 1'b0;
                            if (hz != '0)
                            begin
                                done_next     = 1'b0;
                                is_set_next   = 1'b1;
                                creq.start    = 1'b1;
                                creq.dividend = head.entry.target_ns;
                                state_next    = S_DIV1;
                            end
                            else
                            begin
                                cmp_next   = '0;
                                armed_next = 1'b1;
                            end
                        end
                        K_CANCEL:
                        begin
                            armed_next = 1'b0;
                        end
                        K_RD_FIRED:
                        begin
                            rsp_next.fired = fired_reg;
                            fired_next     = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DIV1:
            begin
                if (cv_done)
                begin
                    s_next     = cv_quot;
                    r_next     = cv_rem;
                    state_next = S_MLO;
                end
            end
            S_MLO:
            begin
                acc_next   = 64'(mul_p);
                state_next = S_MHI;
            end
            S_MHI:
            begin
                acc_next   = acc_reg + {mul_p[31:0], 32'd0};
                state_next = S_MR;
            end
            S_MR:
            begin
                if (is_set_reg)
                begin
                    creq.start    = 1'b1;
                    creq.dividend = 64'(mul_p);
                end
                else
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = 64'(mul_p);
                end
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (cv_done)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (is_set_reg)
                    begin
                        cmp_next   = sum[COUNT_WIDTH-1:0];
                        armed_next = 1'b1;
                    end
                    else
                    begin
                        rsp_next.now_ns = sum;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tick_reg  <= '0;
            cmp_reg   <= '0;
            armed_reg <= 1'b0;
            fired_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            cmp_reg   <= cmp_next;
            armed_reg <= armed_next;
            fired_reg <= fired_next;
            done_reg  <= done_next;
        end
    end

    // Hold conversion operands and the result beat
    always_ff @(posedge clk)
    begin
        is_set_reg <= is_set_next;
        s_reg      <= s_next;
        r_reg      <= r_next;
        acc_reg    <= acc_next;
        rsp_reg    <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

[hw/rtl/deadline_timer_ns_convert_unit.sv]
// Work per command: tick, cancel, read-fired and unused codes complete in the idle state
//   of the back end; set-deadline runs two reciprocal divides by 10^9 plus three multiply
//   steps; read-now runs two divides by the rate in the restoring divider plus three
//   multiply steps; both complete in the idle state if the rate is 0.
// Throughput: one item in flight in the back end; a 2-entry queue takes beats meanwhile.
// Reset (rst_n, async low) clears all timer state and the rate; done strobes, no stall.
`timescale 1ns / 1ps

module deadline_timer_ns_convert_unit
    import dtc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  cmd_t        cmd,
    output logic        busy,
    output logic        done,
    output rsp_t        rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [HZ_W-1:0] hz_reg;
    logic [HZ_W-1:0] hz_next;
    logic            wr_en;
    q_out_t          head;
    logic            pop;
    div_req_t        dreq;
    div_rsp_t        drsp;
    cdiv_req_t       creq;
    div_rsp_t        crsp;

    // Register port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TIMEBASE);
    assign hz_next = wr_en ? pwdata[HZ_W-1:0] : hz_reg;
    assign prdata = (paddr[2] == REG_TIMEBASE) ? {2'b00, hz_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hz_reg <= '0;
        end
        else
        begin
            hz_reg <= hz_next;
        end
    end

    dtc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .pop   (pop),
        .head  (head)
    );

    dtc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    dtc_cdiv u_cdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    dtc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .hz    (hz_reg),
        .head  (head),
        .pop   (pop),
        .dreq  (dreq),
        .drsp  (drsp),
        .creq  (creq),
        .crsp  (crsp),
        .done  (done),
        .rsp   (rsp)
    );

endmodule
